### src/evq_pkg.sv
package evq_pkg;

  localparam int unsigned ID_W       = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TIMER_IN_W = 29;
  // owner codes may run up to 63 (void and init codes)
  localparam int unsigned EVT_W      = 6;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_NUM_EVENTS  = 16;
  localparam int unsigned DEF_VOID_CODE   = 0;
  localparam int unsigned DEF_INIT_CODE   = 1;
  localparam int unsigned DEF_TIMER_BITS  = 29;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_GIVE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DECAY,
    ST_RESP
  } state_e;

  typedef struct packed {
    func_e                   func;
    logic [ID_W-1:0]         event_id;
    logic [WORD_W-1:0]       callback_word;
    logic [WORD_W-1:0]       argument_word;
    logic [TIMER_IN_W-1:0]   timer_now;
  } in_item_t;

  typedef struct packed {
    logic                    event_valid;
    logic [ID_W-1:0]         out_event;
    logic [WORD_W-1:0]       out_callback;
    logic [WORD_W-1:0]       out_argument;
    logic [WORD_W-1:0]       load_value;
    logic                    overflow_error;
    logic [WORD_W-1:0]       error_detail;
  } out_item_t;

endpackage

### src/evq_if.sv
interface evq_in_if import evq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface evq_out_if import evq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/event_queue_with_load_profiler.sv
// Add goes from idle straight to the response state; get and give pass through EXEC, and
// the load query through DECAY, before the result is registered (with the result side ready).
// A new item is taken only once the last one is done; the load query sweeps the accumulator
// memory one entry per cycle (read, halve, write back through its two ports).
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low) empties the queue and zeroes all accumulators at once.
module event_queue_with_load_profiler import evq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned NUM_EVENTS  = DEF_NUM_EVENTS,
  parameter int unsigned VOID_CODE   = DEF_VOID_CODE,
  parameter int unsigned INIT_CODE   = DEF_INIT_CODE,
  parameter int unsigned TIMER_BITS  = DEF_TIMER_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  evq_in_if.sink      evt_i,
  evq_out_if.source   res_o
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned TAW = $clog2(NUM_EVENTS);
  localparam int unsigned QW  = ID_W + 2 * WORD_W;

  typedef struct packed {
    logic [ID_W-1:0]   ev;
    logic [WORD_W-1:0] cb;
    logic [WORD_W-1:0] arg;
  } qent_t;

  state_e                state_q, state_d;
  logic [QAW-1:0]        head_q, head_d, tail_q, tail_d, head_nxt, tail_nxt;
  logic                  ovf_seen_q, ovf_seen_d;
  logic [EVT_W-1:0]      cur_q, cur_d, prev_q, prev_d;
  logic [TIMER_BITS-1:0] stamp_q, stamp_d;
  logic [NUM_EVENTS-1:0] tot_vld_q;
  func_e                 op_q, op_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [TIMER_BITS-1:0] now_q, now_d;
  logic                  hit_q, hit_d;
  logic [TAW:0]          swp_q, swp_d;
  logic [TAW-1:0]        rd_idx_q, rd_idx_d;
  logic                  tot_rvld_q;
  out_item_t             res_q, res_d, out_q;
  logic                  out_vld_q, out_vld_d, out_load;

  logic                  full, empty, acc;
  logic [WORD_W-1:0]     now_ext, stamp_ext, tot_rd;
  logic [TIMER_BITS-1:0] now_in, delta;
  logic [EVT_W-1:0]      ev;
  logic                  cur_charged;

  logic                  q_we, q_re;
  qent_t                 q_wdata, q_rdata;
  logic                  t_we, t_re;
  logic [TAW-1:0]        t_waddr, t_raddr;
  logic [WORD_W-1:0]     t_wdata, t_rdata;

  evq_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (head_q),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (tail_q),
    .rdata_o (q_rdata)
  );

  evq_ram #(.WIDTH(WORD_W), .DEPTH(NUM_EVENTS)) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  assign head_nxt  = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
  assign tail_nxt  = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QAW'(1);
  assign full      = (head_nxt == tail_q);
  assign empty     = (head_q == tail_q);

  assign evt_i.ready = (state_q == ST_IDLE);
  assign acc         = evt_i.valid && evt_i.ready;

  assign now_ext   = WORD_W'(evt_i.payload.timer_now);
  assign now_in    = now_ext[TIMER_BITS-1:0];
  assign stamp_ext = WORD_W'(stamp_q);
  assign delta     = stamp_q - now_q;
  // accumulator entries never written since reset read as zero
  assign tot_rd    = tot_rvld_q ? t_rdata : '0;
  assign cur_charged = ((EVT_W + 1)'(cur_q) < (EVT_W + 1)'(NUM_EVENTS));

  assign q_wdata.ev  = evt_i.payload.event_id;
  assign q_wdata.cb  = evt_i.payload.callback_word;
  assign q_wdata.arg = evt_i.payload.argument_word;

  assign out_load = !out_vld_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ovf_seen_d = ovf_seen_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    stamp_d    = stamp_q;
    op_d       = op_q;
    id_d       = id_q;
    now_d      = now_q;
    hit_d      = hit_q;
    swp_d      = swp_q;
    rd_idx_d   = rd_idx_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    q_we       = 1'b0;
    q_re       = 1'b0;
    t_we       = 1'b0;
    t_re       = 1'b0;
    t_waddr    = cur_q[TAW-1:0];
    t_raddr    = cur_q[TAW-1:0];
    t_wdata    = tot_rd + WORD_W'(delta);
    ev         = prev_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          op_d  = evt_i.payload.func;
          id_d  = evt_i.payload.event_id;
          now_d = now_in;
          res_d = '0;
          unique case (evt_i.payload.func)
            FUNC_ADD: begin
              if (full) begin
                if (!ovf_seen_q) begin
                  res_d.overflow_error = 1'b1;
                  res_d.error_detail   = {stamp_ext[15:0],
                                          16'(evt_i.payload.event_id)};
                  ovf_seen_d           = 1'b1;
                end
              end else begin
                q_we       = 1'b1;
                head_d     = head_nxt;
                ovf_seen_d = 1'b0;
              end
              state_d = ST_RESP;
            end
            FUNC_GET: begin
              hit_d = !empty;
              q_re  = !empty;
              if (!empty) begin
                tail_d = tail_nxt;
              end
              t_re    = 1'b1;
              state_d = ST_EXEC;
            end
            FUNC_GIVE: begin
              t_re    = 1'b1;
              state_d = ST_EXEC;
            end
            FUNC_QUERY: begin
              swp_d   = '0;
              state_d = ST_DECAY;
            end
          endcase
        end
      end

      ST_EXEC: begin
        if (op_q == FUNC_GET) begin
          ev                 = hit_q ? EVT_W'(q_rdata.ev) : EVT_W'(VOID_CODE);
          res_d.event_valid  = hit_q;
          res_d.out_event    = ev[ID_W-1:0];
          res_d.out_callback = hit_q ? q_rdata.cb : '0;
          res_d.out_argument = hit_q ? q_rdata.arg : '0;
        end
        // owner switch: charge elapsed time to the outgoing owner
        if (ev != cur_q) begin
          t_we    = cur_charged;
          prev_d  = cur_q;
          cur_d   = ev;
          stamp_d = now_q;
        end
        state_d = ST_RESP;
      end

      ST_DECAY: begin
        // read entry swp while the one read last cycle is halved and written back
        t_waddr = rd_idx_q;
        t_wdata = tot_rd >> 1;
        t_we    = (swp_q != '0);
        if ((swp_q != '0) && ((EVT_W + 1)'(id_q) == (EVT_W + 1)'(rd_idx_q))) begin
          res_d.load_value = tot_rd >> 1;
        end
        t_raddr = swp_q[TAW-1:0];
        if (swp_q == (TAW + 1)'(NUM_EVENTS)) begin
          state_d = ST_RESP;
        end else begin
          t_re     = 1'b1;
          rd_idx_d = swp_q[TAW-1:0];
          swp_d    = swp_q + (TAW + 1)'(1);
        end
      end

      ST_RESP: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      ovf_seen_q <= 1'b0;
      cur_q      <= EVT_W'(INIT_CODE);
      prev_q     <= '0;
      stamp_q    <= '1;
      tot_vld_q  <= '0;
      swp_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      ovf_seen_q <= ovf_seen_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      stamp_q    <= stamp_d;
      swp_q      <= swp_d;
      out_vld_q  <= out_vld_d;
      if (t_we) begin
        tot_vld_q[t_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    now_q      <= now_d;
    hit_q      <= hit_d;
    rd_idx_q   <= rd_idx_d;
    res_q      <= res_d;
    tot_rvld_q <= tot_vld_q[t_raddr];
    if ((state_q == ST_RESP) && out_load) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

endmodule

### src/evq_ram.sv
module evq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### src/evq_checker.sv
module evq_checker import evq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_payload_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item taken while previous one still in work");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q == 2'd0 || pend_q == 2'd1)
    else $error("too many items outstanding");

endmodule

bind event_queue_with_load_profiler evq_checker u_evq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (evt_i.valid),
  .in_ready_i    (evt_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_payload_i (res_o.payload)
);

### tb/tb_event_queue_with_load_profiler.sv
`timescale 1ns / 100ps

module tb_event_queue_with_load_profiler;
  import evq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTED  = 100;

  // Expected-result tracker: ring contents, owner bookkeeping and the
  // per-event processor time totals, advanced once per accepted item.
  class queue_load_tracker;
    logic [ID_W-1:0]           slot_id  [DEF_QUEUE_DEPTH];
    logic [WORD_W-1:0]         slot_cb  [DEF_QUEUE_DEPTH];
    logic [WORD_W-1:0]         slot_arg [DEF_QUEUE_DEPTH];
    int unsigned               head;
    int unsigned               tail;
    bit                        drop_flagged;
    logic [EVT_W-1:0]          owner;
    logic [EVT_W-1:0]          prev_owner;
    logic [DEF_TIMER_BITS-1:0] switch_stamp;
    logic [WORD_W-1:0]         cpu_time [DEF_NUM_EVENTS];
    out_item_t                 expected_results[$];
    int                        mismatches;
    int                        results_seen;

    function new();
      head         = 0;
      tail         = 0;
      drop_flagged = 1'b0;
      owner        = EVT_W'(DEF_INIT_CODE);
      prev_owner   = '0;
      switch_stamp = '1;
      foreach (cpu_time[i]) cpu_time[i] = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Charge the elapsed down-counter time to the outgoing owner.
    function void hand_over(logic [EVT_W-1:0] next_owner, logic [DEF_TIMER_BITS-1:0] now);
      logic [DEF_TIMER_BITS-1:0] spent;
      if (next_owner != owner) begin
        spent = switch_stamp - now;
        if (owner < DEF_NUM_EVENTS) cpu_time[owner] += WORD_W'(spent);
        prev_owner   = owner;
        owner        = next_owner;
        switch_stamp = now;
      end
    endfunction

    function void note_request(in_item_t it);
      out_item_t                 r;
      int unsigned               nxt;
      logic [DEF_TIMER_BITS-1:0] now;
      logic [EVT_W-1:0]          got_evt;
      r   = '0;
      now = it.timer_now[DEF_TIMER_BITS-1:0];
      case (it.func)
        FUNC_ADD: begin
          nxt = (head + 1) % DEF_QUEUE_DEPTH;
          if (nxt == tail) begin
            // only the first drop after a successful add is flagged
            if (!drop_flagged) begin
              r.overflow_error = 1'b1;
              r.error_detail   = {switch_stamp[15:0], 16'(it.event_id)};
              drop_flagged     = 1'b1;
            end
          end else begin
            drop_flagged   = 1'b0;
            slot_id[head]  = it.event_id;
            slot_cb[head]  = it.callback_word;
            slot_arg[head] = it.argument_word;
            head           = nxt;
          end
        end
        FUNC_GET: begin
          got_evt = EVT_W'(DEF_VOID_CODE);
          if (head != tail) begin
            got_evt        = EVT_W'(slot_id[tail]);
            r.event_valid  = 1'b1;
            r.out_callback = slot_cb[tail];
            r.out_argument = slot_arg[tail];
            tail           = (tail + 1) % DEF_QUEUE_DEPTH;
          end
          r.out_event = got_evt[ID_W-1:0];
          hand_over(got_evt, now);
        end
        FUNC_QUERY: begin
          foreach (cpu_time[i]) begin
            cpu_time[i] = cpu_time[i] >> 1;
            if (i == it.event_id) r.load_value = cpu_time[i];
          end
        end
        default: hand_over(prev_owner, now);
      endcase
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (mismatches < MAX_PRINTED)
        $display("ERROR result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, field, got, want);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.event_valid !== want.event_valid)
        report_mismatch("event_valid", 32'(got.event_valid), 32'(want.event_valid));
      if (got.out_event !== want.out_event)
        report_mismatch("out_event", 32'(got.out_event), 32'(want.out_event));
      if (got.out_callback !== want.out_callback)
        report_mismatch("out_callback", got.out_callback, want.out_callback);
      if (got.out_argument !== want.out_argument)
        report_mismatch("out_argument", got.out_argument, want.out_argument);
      if (got.load_value !== want.load_value)
        report_mismatch("load_value", got.load_value, want.load_value);
      if (got.overflow_error !== want.overflow_error)
        report_mismatch("overflow_error", 32'(got.overflow_error), 32'(want.overflow_error));
      if (got.error_detail !== want.error_detail)
        report_mismatch("error_detail", got.error_detail, want.error_detail);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_count;
  logic [TIMER_IN_W-1:0] tick;
  queue_load_tracker tracker = new();

  evq_in_if  evt_if ();
  evq_out_if res_if ();

  event_queue_with_load_profiler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) tracker.note_request(evt_if.payload);
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) tracker.check_result(res_if.payload);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit zero_ok);
    int r;
    r = $urandom_range(0, 99);
    if (zero_ok && r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // down-counting timer with an occasional jump anywhere in its range
  function automatic void advance_timer();
    if ($urandom_range(0, 19) == 0) tick = TIMER_IN_W'($urandom);
    else tick = tick - TIMER_IN_W'($urandom_range(0, 5000));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(func_e f, logic [ID_W-1:0] id, logic [WORD_W-1:0] cb,
                      logic [WORD_W-1:0] arg, logic [TIMER_IN_W-1:0] now, int gap);
    in_item_t it;
    it.func          = f;
    it.event_id      = id;
    it.callback_word = cb;
    it.argument_word = arg;
    it.timer_now     = now;
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    evt_if.valid   <= 1'b1;
    evt_if.payload <= it;
    do @(posedge clk_i); while (evt_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    evt_if.valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_burst(int kind, bit calm, output int count);
    int len;
    func_e f;
    len = 1;
    case (kind)
      0, 1, 2: len = $urandom_range(4, 20);
      3, 4:    len = $urandom_range(4, 20);
      5:       len = $urandom_range(8, 24);
      6:       len = $urandom_range(4, 16);
      7:       len = $urandom_range(1, 3);
      default: len = $urandom_range(1, 10);
    endcase
    for (int k = 0; k < len; k++) begin
      case (kind)
        0, 1, 2: f = FUNC_ADD;
        3, 4:    f = FUNC_GET;
        5:       f = FUNC_GIVE;
        6:       f = ($urandom_range(0, 1) == 0) ? FUNC_GET : FUNC_GIVE;
        7:       f = FUNC_QUERY;
        default: f = func_e'($urandom_range(0, 3));
      endcase
      // a timer that barely moved up has wrapped: near-maximal charge per give
      if (kind == 5) tick = tick + 1'b1;
      else if (kind >= 8) tick = TIMER_IN_W'($urandom);
      else advance_timer();
      send(f, ID_W'($urandom_range(0, 15)), $urandom, $urandom, tick, calm ? 0 : pick_gap(1'b1));
    end
    count = len;
  endtask

  initial begin : result_sink
    int stall_left;
    bit calm;
    stall_left   = 0;
    calm         = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
    end
  end

  initial begin : stimulus
    int sent;
    int n;
    bit calm;
    sent           = 0;
    n              = 0;
    cycle_count    = 0;
    rst_ni         = 1'b0;
    evt_if.valid   = 1'b0;
    evt_if.payload = '0;
    tick           = '1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // get on an empty ring at timer zero, then give back at timer max
    send(FUNC_GET, '0, '0, '0, '0, 0);
    send(FUNC_GIVE, '0, '0, '0, '1, 1);
    send(FUNC_QUERY, 4'd1, '0, '0, '0, 0);
    // fill the ring: one slot always stays free
    send(FUNC_ADD, 4'd15, '1, '0, '0, 0);
    send(FUNC_ADD, 4'd0, '0, '1, '0, 2);
    for (int k = 0; k < 13; k++)
      send(FUNC_ADD, ID_W'($urandom_range(0, 15)), $urandom, $urandom, '0, pick_gap(1'b1));
    // first drop is flagged, the second one is silent
    send(FUNC_ADD, 4'd15, $urandom, $urandom, '0, 0);
    send(FUNC_ADD, 4'd3, $urandom, $urandom, '0, 0);
    send(FUNC_GET, '0, '0, '0, 29'h0FFF_FFFF, 0);
    send(FUNC_ADD, 4'd9, '1, '1, '0, 0);
    send(FUNC_ADD, 4'd12, '0, '0, '0, 0);
    send(FUNC_QUERY, 4'd15, '0, '0, '0, 3);
    send(FUNC_QUERY, 4'd0, '0, '0, '0, 0);
    wait_for_results();

    // push large charges onto both alternating owners toward the 32-bit wrap, with no decay in the burst
    tick = TIMER_IN_W'($urandom);
    send_burst(5, 1'b1, n);
    sent += n;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      send_burst($urandom_range(0, 9), calm, n);
      sent += n;
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
